// ===== hdl/tlrf_pkg.sv =====
// Shared types and constants for the trace live-in register finder.
package tlrf_pkg;

    localparam int REG_IDX_W = 6;   // register index width on the trace record
    localparam int VALUE_W   = 32;  // register value width
    localparam int OUT_IDX_W = 5;   // reported register index width
    localparam int COUNT_W   = 6;   // reported live-in count width
    localparam int NUM_SLOTS = 4;   // source checks per record: implicit, src1..src3
    localparam int SLOT_W    = 2;   // selects the source slot that captured a value
    localparam int MAX_OUT   = 32;  // most results in one report
    localparam int COUNT_SAT = 63;  // reported count saturates here

    // One trace record
    typedef struct packed {
        logic [REG_IDX_W-1:0] impl_idx;
        logic [VALUE_W-1:0]   impl_value;
        logic [REG_IDX_W-1:0] src1_idx;
        logic [VALUE_W-1:0]   src1_value;
        logic [REG_IDX_W-1:0] src2_idx;
        logic [VALUE_W-1:0]   src2_value;
        logic [REG_IDX_W-1:0] src3_idx;
        logic [VALUE_W-1:0]   src3_value;
        logic [REG_IDX_W-1:0] dest_reg;
        logic                 trace_end;
    } t_in;

    // One report entry
    typedef struct packed {
        logic [OUT_IDX_W-1:0] reg_index;
        logic [VALUE_W-1:0]   reg_value;
        logic [COUNT_W-1:0]   live_count;
        logic                 run_last;
    } t_out;

    // Report kick-off from the update stage
    typedef struct packed {
        logic               start;
        logic               empty;
        logic [COUNT_W-1:0] shown;
    } t_rep_start;

endpackage

// ===== hdl/tlrf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tlrf_update.sv =====
// Record register and live-in / written mask update for one trace record per cycle while no report holds off input.
module tlrf_update #(
    parameter int NUM_REGS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tlrf_pkg::t_in               i_in_data,
    input  logic                        i_busy,
    output logic                        o_we    [tlrf_pkg::NUM_SLOTS],
    output logic [$clog2(NUM_REGS)-1:0] o_waddr [tlrf_pkg::NUM_SLOTS],
    output logic [tlrf_pkg::VALUE_W-1:0] o_wdata [tlrf_pkg::NUM_SLOTS],
    output logic [tlrf_pkg::SLOT_W-1:0] o_tag   [NUM_REGS],
    output logic [NUM_REGS-1:0]         o_live_mask,
    output tlrf_pkg::t_rep_start        o_start
);

    import tlrf_pkg::*;

    localparam int AW = $clog2(NUM_REGS);
    localparam int CW = $clog2(NUM_REGS + 1);
    localparam logic [REG_IDX_W:0] NUM_REGS_V = (REG_IDX_W + 1)'(NUM_REGS);

    logic                  r_in_vld;
    t_in                   r_in;
    logic [NUM_REGS-1:0]   r_written;
    logic [NUM_REGS-1:0]   n_written;
    logic [NUM_REGS-1:0]   r_live;
    logic [NUM_REGS-1:0]   n_live;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [SLOT_W-1:0]     r_tag [NUM_REGS];

    logic [REG_IDX_W-1:0]  slot_reg [NUM_SLOTS];
    logic [VALUE_W-1:0]    slot_val [NUM_SLOTS];
    logic [AW-1:0]         slot_idx [NUM_SLOTS];
    logic                  slot_ok  [NUM_SLOTS];
    logic                  cap      [NUM_SLOTS];
    logic                  dest_ok;
    logic [AW-1:0]         dest_idx;
    logic                  in_xfer;
    logic                  end_rec;

    // hold off a new record while a report is pending
    assign end_rec    = r_in_vld && r_in.trace_end;
    assign o_in_ready = !i_busy && !end_rec;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign slot_reg[0] = r_in.impl_idx;
    assign slot_reg[1] = r_in.src1_idx;
    assign slot_reg[2] = r_in.src2_idx;
    assign slot_reg[3] = r_in.src3_idx;
    assign slot_val[0] = r_in.impl_value;
    assign slot_val[1] = r_in.src1_value;
    assign slot_val[2] = r_in.src2_value;
    assign slot_val[3] = r_in.src3_value;

    // source checks in priority order; a repeat of an earlier slot never captures
    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_ok[k]  = r_in_vld && ({1'b0, slot_reg[k]} < NUM_REGS_V);
            slot_idx[k] = slot_reg[k][AW-1:0];
            cap[k]      = slot_ok[k] && !r_written[slot_idx[k]] && !r_live[slot_idx[k]];
            for (int j = 0; j < k; j++) begin
                if (slot_reg[j] == slot_reg[k]) begin
                    cap[k] = 1'b0;
                end
            end
        end
    end

    // next masks and running count
    always_comb begin
        dest_ok   = r_in_vld && ({1'b0, r_in.dest_reg} < NUM_REGS_V);
        dest_idx  = r_in.dest_reg[AW-1:0];
        n_live    = r_live;
        n_count   = r_count;
        n_written = r_written;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (cap[k]) begin
                n_live[slot_idx[k]] = 1'b1;
                n_count = n_count + CW'(1);
            end
        end
        if (dest_ok) begin
            n_written[dest_idx] = 1'b1;
        end
    end

    // report kick-off on the trace-ending record
    always_comb begin
        o_start.start = end_rec;
        o_start.empty = (n_live == '0);
        if (32'(n_count) > 32'(COUNT_SAT)) begin
            o_start.shown = COUNT_W'(COUNT_SAT);
        end else begin
            o_start.shown = COUNT_W'(n_count);
        end
    end

    assign o_live_mask = n_live;

    // capture writes, one RAM bank per source slot
    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            o_we[k]    = cap[k];
            o_waddr[k] = slot_idx[k];
            o_wdata[k] = slot_val[k];
        end
    end

    // record register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_xfer;
        end
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    // trace state; cleared after the trace-ending record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || end_rec) begin
            r_written <= '0;
            r_live    <= '0;
            r_count   <= '0;
        end else begin
            r_written <= n_written;
            r_live    <= n_live;
            r_count   <= n_count;
        end
    end

    // which bank holds each register's captured value
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (cap[k]) begin
                r_tag[slot_idx[k]] <= SLOT_W'(k);
            end
        end
    end

    assign o_tag = r_tag;

endmodule

// ===== hdl/tlrf_report.sv =====
// Report sequencer: scans the live-in mask, reads captured values, drives results.
module tlrf_report #(
    parameter int NUM_REGS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tlrf_pkg::t_rep_start         i_start,
    input  logic [NUM_REGS-1:0]          i_live_mask,
    input  logic [tlrf_pkg::SLOT_W-1:0]  i_tag   [NUM_REGS],
    output logic                         o_busy,
    output logic                         o_re,
    output logic [$clog2(NUM_REGS)-1:0]  o_raddr,
    input  logic [tlrf_pkg::VALUE_W-1:0] i_rdata [tlrf_pkg::NUM_SLOTS],
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tlrf_pkg::t_out               o_out_data
);

    import tlrf_pkg::*;

    localparam int AW = $clog2(NUM_REGS);
    localparam int EW = $clog2(MAX_OUT);

    // scan state
    logic                r_busy;
    logic [NUM_REGS-1:0] r_mask;
    logic                r_empty;
    logic [COUNT_W-1:0]  r_shown;
    logic [EW-1:0]       r_emitted;

    // read stage
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_idx;
    logic [SLOT_W-1:0]   r_rd_tag;
    logic                r_rd_last;
    logic                r_rd_empty;
    logic [COUNT_W-1:0]  r_rd_shown;

    // result register
    logic                r_out_vld;
    t_out                r_out;

    logic                out_free;
    logic                rd_adv;
    logic                issue;
    logic [AW-1:0]       first_idx;
    logic [NUM_REGS-1:0] rest;
    logic                is_last;

    assign out_free = !r_out_vld || i_out_ready;
    assign rd_adv   = !r_rd_vld || out_free;
    assign issue    = r_busy && rd_adv;

    // lowest pending live-in register
    always_comb begin
        first_idx = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                first_idx = AW'(i);
            end
        end
    end

    assign rest    = r_mask & (r_mask - NUM_REGS'(1));
    assign is_last = r_empty || (rest == '0) || (r_emitted == EW'(MAX_OUT - 1));

    // scan sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start.start) begin
            r_busy <= 1'b1;
        end else if (issue && is_last) begin
            r_busy <= 1'b0;
        end
        if (i_start.start) begin
            r_mask    <= i_live_mask;
            r_empty   <= i_start.empty;
            r_shown   <= i_start.shown;
            r_emitted <= '0;
        end else if (issue) begin
            r_mask    <= rest;
            r_emitted <= r_emitted + EW'(1);
        end
    end

    // read stage, advances with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (rd_adv) begin
            r_rd_vld <= issue;
        end
        if (issue) begin
            r_rd_idx   <= first_idx;
            r_rd_tag   <= i_tag[first_idx];
            r_rd_last  <= is_last;
            r_rd_empty <= r_empty;
            r_rd_shown <= r_shown;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_rd_vld;
        end
        if (out_free && r_rd_vld) begin
            r_out.reg_index  <= r_rd_empty ? '0 : OUT_IDX_W'(r_rd_idx);
            r_out.reg_value  <= r_rd_empty ? '0 : i_rdata[r_rd_tag];
            r_out.live_count <= r_rd_shown;
            r_out.run_last   <= r_rd_last;
        end
    end

    assign o_busy      = r_busy;
    assign o_re        = issue;
    assign o_raddr     = first_idx;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/trace_live_in_register_finder.sv =====
// Top level of the trace live-in register finder.
// Throughput: one record per cycle unless held off; one result per cycle in a report unless stalled.
// The first result of a report passes the record, scan, read-stage and result registers.
// After a trace-ending record, input is held off until the report's last bank read is issued.
// Each value bank has one read port.
// Reset (synchronous, active low) clears masks, count and handshake state; value banks are not reset.
module trace_live_in_register_finder #(
    parameter int NUM_REGS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tlrf_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tlrf_pkg::t_out o_out_data
);

    import tlrf_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    logic               we    [NUM_SLOTS];
    logic [AW-1:0]      waddr [NUM_SLOTS];
    logic [VALUE_W-1:0] wdata [NUM_SLOTS];
    logic [VALUE_W-1:0] rdata [NUM_SLOTS];
    logic [SLOT_W-1:0]  tag   [NUM_REGS];
    logic [NUM_REGS-1:0] live_mask;
    t_rep_start         rep_start;
    logic               busy;
    logic               re;
    logic [AW-1:0]      raddr;

    tlrf_update #(
        .NUM_REGS (NUM_REGS)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_busy      (busy),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_tag       (tag),
        .o_live_mask (live_mask),
        .o_start     (rep_start)
    );

    // one value bank per source slot
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_bank
        tlrf_ram #(
            .WIDTH (VALUE_W),
            .DEPTH (NUM_REGS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[k]),
            .i_waddr (waddr[k]),
            .i_wdata (wdata[k]),
            .i_re    (re),
            .i_raddr (raddr),
            .o_rdata (rdata[k])
        );
    end

    tlrf_report #(
        .NUM_REGS (NUM_REGS)
    ) u_report (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (rep_start),
        .i_live_mask (live_mask),
        .i_tag       (tag),
        .o_busy      (busy),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/tlrf_checker.sv =====
// Port-level checks for the trace live-in register finder, bound to the top level.
module tlrf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input tlrf_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input tlrf_pkg::t_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // an empty report is a single all-zero final entry
    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.live_count == '0 |->
            o_out_data.run_last && o_out_data.reg_index == '0 && o_out_data.reg_value == '0)
        else $error("malformed empty report");

    // input is held off right after a trace-ending record
    a_end_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.trace_end |=> !o_in_ready)
        else $error("record taken behind a trace-ending record");

    // a report runs without gaps until its final entry
    a_report_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.run_last |=> o_out_valid)
        else $error("gap inside a report");

endmodule

bind trace_live_in_register_finder tlrf_checker u_tlrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
